// ===== rtl/nqe_pkg.sv =====
// ----------------------------------------------------------------------------
// nqe_pkg
// shared constants and types for the n-queens node expander
// ----------------------------------------------------------------------------
package nqe_pkg;

  localparam int BoardSize = 14;
  localparam int Slots     = 14;
  localparam int MaxOut    = 14;
  localparam int ColW      = 4;
  localparam int RowsW     = 4;
  localparam int PlaceW    = Slots * ColW;
  localparam int CntW      = $clog2(MaxOut);

  localparam logic [ColW-1:0] EmptySlot = '1;

  typedef logic [BoardSize-1:0] col_mask_t;

  typedef struct packed {
    logic [RowsW-1:0]  rows;
    logic [PlaceW-1:0] base;
    col_mask_t         safe;
  } parent_t;

endpackage

// ===== rtl/nqe_safe_mask.sv =====
// ----------------------------------------------------------------------------
// nqe_safe_mask
// column and diagonal conflict check of every column against every placed row
// ----------------------------------------------------------------------------
module nqe_safe_mask import nqe_pkg::*; (
  input  logic [RowsW-1:0]  rows_i,
  input  logic [PlaceW-1:0] placement_i,
  output parent_t           parent_o
);

  logic room;

  assign room = (32'(rows_i) < BoardSize) && (32'(rows_i) < Slots);

  always_comb begin
    logic [ColW-1:0]  q;
    logic [ColW-1:0]  c;
    logic [ColW-1:0]  span;
    logic [RowsW-1:0] gap;
    logic             ok;
    parent_o.rows = rows_i;
    for (int r = 0; r < Slots; r++) begin
      if (RowsW'(r) < rows_i) begin
        parent_o.base[r*ColW +: ColW] = placement_i[r*ColW +: ColW];
      end else begin
        parent_o.base[r*ColW +: ColW] = EmptySlot;
      end
    end
    for (int col = 0; col < BoardSize; col++) begin
      c  = ColW'(col);
      ok = room;
      for (int r = 0; r < Slots; r++) begin
        q    = placement_i[r*ColW +: ColW];
        span = (q > c) ? (q - c) : (c - q);
        gap  = rows_i - RowsW'(r);
        if (RowsW'(r) < rows_i) begin
          if ((q == c) || (span == gap)) begin
            ok = 1'b0;
          end
        end
      end
      parent_o.safe[col] = ok;
    end
  end

endmodule

// ===== rtl/nqe_emitter.sv =====
// ----------------------------------------------------------------------------
// nqe_emitter
// walks the safe column mask, one child item per cycle into the result register
// ----------------------------------------------------------------------------
module nqe_emitter import nqe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  parent_t           parent_i,
  output logic              ready_o,
  output logic              valid_o,
  output logic              child_valid_o,
  output logic [PlaceW-1:0] child_placement_o,
  output logic [RowsW-1:0]  child_rows_o,
  output logic [ColW-1:0]   new_column_o,
  output logic              is_solution_o,
  output logic              last_o
);

  logic              active_q, active_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  col_mask_t         mask_q, mask_d;
  logic [RowsW-1:0]  rows_q, rows_d;
  logic [PlaceW-1:0] base_q, base_d;

  logic              valid_q;
  logic              child_valid_q;
  logic [PlaceW-1:0] child_placement_q;
  logic [RowsW-1:0]  child_rows_q;
  logic [ColW-1:0]   new_column_q;
  logic              is_solution_q;
  logic              last_q;

  logic [ColW-1:0]   sel;
  col_mask_t         remaining;
  logic              marker;
  logic              fin;
  logic [PlaceW-1:0] placed;

  always_comb begin
    sel = '0;
    for (int i = BoardSize - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = ColW'(i);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < Slots; r++) begin
      if (RowsW'(r) == rows_q) begin
        placed[r*ColW +: ColW] = sel;
      end else begin
        placed[r*ColW +: ColW] = base_q[r*ColW +: ColW];
      end
    end
  end

  assign remaining = mask_q & ~(col_mask_t'(1) << sel);
  assign marker    = (mask_q == '0);
  assign fin       = marker || (remaining == '0) || (32'(cnt_q) == MaxOut - 1);
  assign ready_o   = !active_q || fin;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    mask_d   = mask_q;
    rows_d   = rows_q;
    base_d   = base_q;
    if (load_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      mask_d   = parent_i.safe;
      rows_d   = parent_i.rows;
      base_d   = parent_i.base;
    end else if (active_q && fin) begin
      active_d = 1'b0;
    end else if (active_q) begin
      mask_d = remaining;
      cnt_d  = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      valid_q  <= active_q;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    rows_q <= rows_d;
    base_q <= base_d;
    if (active_q) begin
      last_q <= fin;
      if (marker) begin
        child_valid_q     <= 1'b0;
        child_placement_q <= '0;
        child_rows_q      <= '0;
        new_column_q      <= '0;
        is_solution_q     <= 1'b0;
      end else begin
        child_valid_q     <= 1'b1;
        child_placement_q <= placed;
        child_rows_q      <= rows_q + RowsW'(1);
        new_column_q      <= sel;
        is_solution_q     <= (32'(rows_q) + 1 == BoardSize);
      end
    end
  end

  assign valid_o           = valid_q;
  assign child_valid_o     = child_valid_q;
  assign child_placement_o = child_placement_q;
  assign child_rows_o      = child_rows_q;
  assign new_column_o      = new_column_q;
  assign is_solution_o     = is_solution_q;
  assign last_o            = last_q;

endmodule

// ===== rtl/nqueens_node_expander.sv =====
// ----------------------------------------------------------------------------
// nqueens_node_expander
// expands one partial n-queens placement into its safe child placements
// ----------------------------------------------------------------------------
// channel  | ports                                              | handshake
// ---------+----------------------------------------------------+----------------
// item in  | placed_rows_i, placement_i                         | start_i, busy_o
// result   | child_valid_o, child_placement_o, child_rows_o,    | valid_o strobe
//          | new_column_o, is_solution_o, last_o                |
//
// an item gives one result per safe column, or one empty marker, one result a
// cycle, at most 14 results per item
// first result path: item register, column mask register, then result register
// the next item moves into the emitter while the previous one emits its last result
// reset clears only control flags; no clearing pass
// results cannot be stalled
module nqueens_node_expander import nqe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [RowsW-1:0]  placed_rows_i,
  input  logic [PlaceW-1:0] placement_i,
  output logic              valid_o,
  output logic              child_valid_o,
  output logic [PlaceW-1:0] child_placement_o,
  output logic [RowsW-1:0]  child_rows_o,
  output logic [ColW-1:0]   new_column_o,
  output logic              is_solution_o,
  output logic              last_o
);

  logic              held_q, held_d;
  logic [RowsW-1:0]  rows_q;
  logic [PlaceW-1:0] placement_q;
  logic              em_ready;
  logic              move;
  logic              accept;
  parent_t           parent;

  assign move   = held_q && em_ready;
  assign busy_o = held_q && !em_ready;
  assign accept = start_i && !busy_o;

  always_comb begin
    held_d = held_q;
    if (accept) begin
      held_d = 1'b1;
    end else if (move) begin
      held_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rows_q      <= placed_rows_i;
      placement_q <= placement_i;
    end
  end

  nqe_safe_mask u_safe_mask (
    .rows_i      (rows_q),
    .placement_i (placement_q),
    .parent_o    (parent)
  );

  nqe_emitter u_emitter (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (move),
    .parent_i          (parent),
    .ready_o           (em_ready),
    .valid_o           (valid_o),
    .child_valid_o     (child_valid_o),
    .child_placement_o (child_placement_o),
    .child_rows_o      (child_rows_o),
    .new_column_o      (new_column_o),
    .is_solution_o     (is_solution_o),
    .last_o            (last_o)
  );

endmodule

// ===== rtl/nqe_checker.sv =====
// ----------------------------------------------------------------------------
// nqe_checker
// port-level checks of the result stream of the node expander
// ----------------------------------------------------------------------------
module nqe_checker import nqe_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              valid_o,
  input logic              child_valid_o,
  input logic [PlaceW-1:0] child_placement_o,
  input logic [RowsW-1:0]  child_rows_o,
  input logic [ColW-1:0]   new_column_o,
  input logic              is_solution_o,
  input logic              last_o
);

  // a marker always closes its item
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !child_valid_o |-> last_o)
    else $error("marker item without last");

  a_marker_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !child_valid_o |->
      (child_placement_o == '0) && (new_column_o == '0) && !is_solution_o &&
      (child_rows_o == '0))
    else $error("marker item carries data");

  // children of one item come out without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && child_valid_o && !last_o |=> valid_o)
    else $error("gap inside a run of children");

  a_solution: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_solution_o |-> child_valid_o && (child_rows_o == RowsW'(BoardSize)))
    else $error("solution flag on a partial board");

  // the expander never stays busy without an item held
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy raised without an item");

endmodule

bind nqueens_node_expander nqe_checker u_nqe_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .valid_o           (valid_o),
  .child_valid_o     (child_valid_o),
  .child_placement_o (child_placement_o),
  .child_rows_o      (child_rows_o),
  .new_column_o      (new_column_o),
  .is_solution_o     (is_solution_o),
  .last_o            (last_o)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// regression for the n-queens node expander: directed corner nodes, then
// random descents through the search tree mixed with noise, each item checked
// field by field against an in-bench expansion of the same node
// ----------------------------------------------------------------------------
module tb;
  import nqe_pkg::*;

  typedef struct packed {
    logic              child_valid;
    logic [PlaceW-1:0] child_placement;
    logic [RowsW-1:0]  child_rows;
    logic [ColW-1:0]   new_column;
    logic              is_solution;
    logic              last;
  } child_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [RowsW-1:0]  placed_rows_i = '0;
  logic [PlaceW-1:0] placement_i = '0;
  logic              valid_o;
  logic              child_valid_o;
  logic [PlaceW-1:0] child_placement_o;
  logic [RowsW-1:0]  child_rows_o;
  logic [ColW-1:0]   new_column_o;
  logic              is_solution_o;
  logic              last_o;

  child_t pending_children[$];
  child_t node_children[$];
  int     mismatch_count = 0;
  int     gap_free_left = 0;

  nqueens_node_expander DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("nqueens_node_expander regression: fail");
    $finish;
  end

  // children of one node, scanned column by column
  function automatic void expand_node(input logic [RowsW-1:0] rows,
                                      input logic [PlaceW-1:0] place);
    logic [PlaceW-1:0] base;
    child_t            kid;
    int                q;
    int                span;
    bit                safe;
    node_children.delete();
    if (rows < BoardSize && rows < Slots) begin
      for (int r = 0; r < Slots; r++) begin
        base[ColW*r +: ColW] = (r < rows) ? place[ColW*r +: ColW] : EmptySlot;
      end
      for (int c = 0; c < BoardSize && node_children.size() < MaxOut; c++) begin
        safe = 1'b1;
        for (int r = 0; r < int'(rows); r++) begin
          q = int'(place[ColW*r +: ColW]);
          span = (q > c) ? q - c : c - q;
          if (q == c || span == int'(rows) - r) safe = 1'b0;
        end
        if (safe) begin
          kid = '0;
          kid.child_valid = 1'b1;
          kid.child_placement = base;
          kid.child_placement[ColW*rows +: ColW] = ColW'(c);
          kid.child_rows = rows + 1'b1;
          kid.new_column = ColW'(c);
          kid.is_solution = (int'(rows) + 1 == BoardSize);
          node_children.push_back(kid);
        end
      end
    end
    if (node_children.size() == 0) begin
      kid = '0;
      kid.last = 1'b1;
      node_children.push_back(kid);
    end else begin
      node_children[node_children.size()-1].last = 1'b1;
    end
  endfunction

  // one item: optional idle gap, then hold start until taken
  task automatic send_node(input logic [RowsW-1:0] rows, input logic [PlaceW-1:0] place);
    int gap;
    if (gap_free_left > 0) begin
      gap = 0;
      gap_free_left--;
    end else begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 19) == 0) gap_free_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    placed_rows_i <= rows;
    placement_i <= place;
    do @(posedge clk_i); while (busy_o);
    expand_node(rows, place);
    foreach (node_children[i]) pending_children.push_back(node_children[i]);
  endtask

  task automatic report_field(input string field, input logic [PlaceW-1:0] exp_val,
                              input logic [PlaceW-1:0] act_val);
    if (exp_val !== act_val) begin
      if (mismatch_count < 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, exp_val,
                 act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    child_t oldest;
    if (rst_ni && valid_o) begin
      if (pending_children.size() == 0) begin
        if (mismatch_count < 10) $display("%0t: result with none expected", $realtime);
        mismatch_count++;
      end else begin
        oldest = pending_children.pop_front();
        report_field("child_valid", PlaceW'(oldest.child_valid), PlaceW'(child_valid_o));
        report_field("child_placement", oldest.child_placement, child_placement_o);
        report_field("child_rows", PlaceW'(oldest.child_rows), PlaceW'(child_rows_o));
        report_field("new_column", PlaceW'(oldest.new_column), PlaceW'(new_column_o));
        report_field("is_solution", PlaceW'(oldest.is_solution), PlaceW'(is_solution_o));
        report_field("last", PlaceW'(oldest.last), PlaceW'(last_o));
      end
    end
  end

  function automatic logic [PlaceW-1:0] random_placement();
    return PlaceW'({$urandom(), $urandom()});
  endfunction

  task automatic test_empty_board();
    send_node('0, '0);
    send_node('0, '1);
    send_node('0, random_placement());
  endtask

  task automatic test_rows_out_of_range();
    send_node(RowsW'(BoardSize), random_placement());
    send_node('1, '1);
    send_node('1, '0);
  endtask

  task automatic test_completing_row();
    int                solution[Slots] = '{1, 3, 5, 7, 9, 11, 13, 2, 0, 6, 8, 10, 12, 4};
    logic [PlaceW-1:0] place;
    place = '1;
    for (int r = 0; r < Slots - 1; r++) place[ColW*r +: ColW] = ColW'(solution[r]);
    send_node(RowsW'(Slots - 1), place);
    send_node(RowsW'(Slots - 2), place);
  endtask

  task automatic test_dead_end();
    logic [PlaceW-1:0] place;
    place = random_placement();
    for (int r = 0; r < Slots - 1; r++) place[ColW*r +: ColW] = ColW'(r);
    send_node(RowsW'(Slots - 1), place);
    send_node(RowsW'(Slots - 1), '0);
  endtask

  task automatic test_out_of_range_columns();
    send_node(4'd1, {52'd0, 4'd14});
    send_node(4'd1, {52'd0, 4'd15});
    send_node(4'd2, {48'd0, 4'd0, 4'd15});
    send_node(4'd3, '1);
  endtask

  // descend through random children, sometimes corrupting a stored column
  task automatic test_random_descents(input int items);
    logic [RowsW-1:0]  rows;
    logic [PlaceW-1:0] place;
    int                pick;
    int                slot;
    rows = '0;
    place = random_placement();
    repeat (items) begin
      send_node(rows, place);
      if (node_children[0].child_valid && !node_children[0].is_solution) begin
        pick = $urandom_range(0, node_children.size() - 1);
        rows = node_children[pick].child_rows;
        place = node_children[pick].child_placement;
        if ($urandom_range(0, 9) == 0) begin
          slot = $urandom_range(0, Slots - 1);
          place[ColW*slot +: ColW] = ColW'($urandom_range(0, 15));
        end
      end else begin
        rows = '0;
        place = random_placement();
      end
    end
  endtask

  task automatic test_random_noise(input int items);
    repeat (items) send_node(RowsW'($urandom_range(0, 15)), random_placement());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_board();
    test_rows_out_of_range();
    test_completing_row();
    test_dead_end();
    test_out_of_range_columns();
    test_random_descents(190);
    test_random_noise(70);
    start_i <= 1'b0;
    while (pending_children.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("nqueens_node_expander regression: pass");
    end else begin
      $display("nqueens_node_expander regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/nqe_pkg.sv
rtl/nqe_safe_mask.sv
rtl/nqe_emitter.sv
rtl/nqueens_node_expander.sv
rtl/nqe_checker.sv
test/tb.sv
